// ----- src/crc8_framed_packet_receiver_unit_macros.svh -----
// assertion macros shared by the packet receiver rtl
// no dependencies; included by files that carry concurrent checks
`ifndef CRC8_FRAMED_PACKET_RECEIVER_UNIT_MACROS_SVH
`define CRC8_FRAMED_PACKET_RECEIVER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CRC8FPR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("crc8fpr same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define CRC8FPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("crc8fpr next-cycle check failed");

`endif

// ----- src/crc8fpr_pkg.sv -----
// shared types, constants and the crc-8 byte update for the packet receiver
// no dependencies
package crc8fpr_pkg;

	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	localparam logic [7:0] CRC_INIT     = 8'hFF;
	localparam logic [7:0] CRC_POLY     = 8'h07;
	localparam logic [7:0] ABORT_BYTE   = 8'hFF;
	localparam logic [7:0] START_RESET  = 8'h02;
	localparam logic [7:0] END_RESET    = 8'h03;

	// item kind
	localparam logic CMD_BYTE    = 1'b0;
	localparam logic CMD_TIMEOUT = 1'b1;

	// register index, taken from paddr bit 2
	typedef enum logic {
		REG_START_BYTE = 1'b0,
		REG_END_BYTE   = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_HUNT_ABORT = 2'd1,
		ST_BAD_END    = 2'd2,
		ST_BAD_CRC    = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] end_byte;
	} cfg_t;

	typedef struct packed {
		logic       command;
		logic [7:0] rx_byte;
	} rx_item_t;

	typedef struct packed {
		logic       valid_res;
		status_t    status;
		logic [7:0] cmd;
		logic [7:0] table_index;
		logic [7:0] param;
	} result_t;

	// one byte through crc-8, msb first
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- src/crc8fpr_rx_if.sv -----
// valid/ready channel carrying one received byte or timeout event
// no dependencies
interface crc8fpr_rx_if;

	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] rx_byte;

	modport source (output valid, output command, output rx_byte, input ready);
	modport sink (input valid, input command, input rx_byte, output ready);

endinterface

// ----- src/crc8fpr_frame_if.sv -----
// valid/ready channel carrying one frame result
// no dependencies
interface crc8fpr_frame_if;

	logic       valid;
	logic       ready;
	logic       valid_res;
	logic [1:0] status;
	logic [7:0] cmd;
	logic [7:0] table_index;
	logic [7:0] param;

	modport source (
		output valid, output valid_res, output status, output cmd,
		output table_index, output param, input ready
	);
	modport sink (
		input valid, input valid_res, input status, input cmd,
		input table_index, input param, output ready
	);

endinterface

// ----- src/crc8_framed_packet_receiver_unit.sv -----
// order: a frame's last byte is registered in the input stage, then its result in the result register
// throughput: one item per cycle unless a held result stalls; input stage refills while the result register drains
// input stage register, one state machine step, then the result register
// arst_n low clears the frame state to hunting, crc to 0xff, held bytes to zero,
// both channels empty and the start/end registers to 0x02/0x03
`include "crc8_framed_packet_receiver_unit_macros.svh"

module crc8_framed_packet_receiver_unit import crc8fpr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	crc8fpr_rx_if.sink            rx,
	crc8fpr_frame_if.source       frame,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t     cfg;
	rx_item_t item_s1;
	logic     valid_s1;
	logic     advance;
	logic     out_free;
	logic     emit;
	result_t  res;
	result_t  res_s2;
	logic     res_valid_s2;

	// configuration registers
	crc8fpr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake control
	assign out_free = !res_valid_s2 || frame.ready;
	assign advance  = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			item_s1.command <= rx.command;
			item_s1.rx_byte <= rx.rx_byte;
		end
	end

	// frame state machine
	crc8fpr_deframer u_deframer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.emit   (emit),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance && emit) begin
			res_valid_s2 <= 1'b1;
		end else if (frame.ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_s2 <= res;
		end
	end

	assign frame.valid       = res_valid_s2;
	assign frame.valid_res   = res_s2.valid_res;
	assign frame.status      = res_s2.status;
	assign frame.cmd         = res_s2.cmd;
	assign frame.table_index = res_s2.table_index;
	assign frame.param       = res_s2.param;

	// checks
	`CRC8FPR_ASSERT_NEXT(a_stage_kept_on_stall, clk, arst_n, valid_s1 && !advance, valid_s1)
	`CRC8FPR_ASSERT_NEXT(a_accept_fills_stage, clk, arst_n, rx.valid && rx.ready, valid_s1)
	`CRC8FPR_ASSERT_NEXT(a_emit_loads_result, clk, arst_n, advance && emit, res_valid_s2)

endmodule

// ----- src/crc8fpr_cfg_regs.sv -----
// apb register file: start and end byte of a frame
// depends on crc8fpr_pkg
module crc8fpr_cfg_regs import crc8fpr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic [7:0] start_byte_q;
	logic [7:0] end_byte_q;
	logic       wr_en;
	reg_idx_t   reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[2]);

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_RESET;
			end_byte_q   <= END_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_START_BYTE: start_byte_q <= pwdata[7:0];
				REG_END_BYTE:   end_byte_q   <= pwdata[7:0];
				default:        ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_START_BYTE: prdata = {{(APB_DATA_W-8){1'b0}}, start_byte_q};
			REG_END_BYTE:   prdata = {{(APB_DATA_W-8){1'b0}}, end_byte_q};
			default:        prdata = '0;
		endcase
	end

	assign cfg.start_byte = start_byte_q;
	assign cfg.end_byte   = end_byte_q;

endmodule

// ----- src/crc8fpr_deframer.sv -----
// frame state machine with running crc-8 and held frame bytes
// depends on crc8fpr_pkg and the assertion macro header
`include "crc8_framed_packet_receiver_unit_macros.svh"

module crc8fpr_deframer import crc8fpr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  rx_item_t item,
	input  cfg_t     cfg,
	output logic     emit,
	output result_t  res
);

	typedef enum logic [5:0] {
		S_HUNT = 6'b000001,
		S_CMD  = 6'b000010,
		S_TBL  = 6'b000100,
		S_PRM  = 6'b001000,
		S_CRC  = 6'b010000,
		S_ETX  = 6'b100000
	} frame_state_t;

	frame_state_t state_q, state_d;
	logic [7:0]   crc_q, crc_d;
	logic [7:0]   cmd_q, cmd_d;
	logic [7:0]   tbl_q, tbl_d;
	logic [7:0]   prm_q, prm_d;
	logic         match_q, match_d;
	logic [7:0]   b;
	logic [7:0]   crc_upd;

	// a timeout counts as the abort byte
	assign b       = (item.command == CMD_TIMEOUT) ? ABORT_BYTE : item.rx_byte;
	assign crc_upd = crc8_update(crc_q, b);

	// next state and result
	always_comb begin
		state_d = state_q;
		crc_d   = crc_q;
		cmd_d   = cmd_q;
		tbl_d   = tbl_q;
		prm_d   = prm_q;
		match_d = match_q;
		emit    = 1'b0;
		res     = '0;
		unique case (state_q)
			S_CMD: begin
				cmd_d   = b;
				crc_d   = crc_upd;
				state_d = S_TBL;
			end
			S_TBL: begin
				tbl_d   = b;
				crc_d   = crc_upd;
				state_d = S_PRM;
			end
			S_PRM: begin
				prm_d   = b;
				crc_d   = crc_upd;
				state_d = S_CRC;
			end
			S_CRC: begin
				match_d = (crc_q == b);
				state_d = S_ETX;
			end
			S_ETX: begin
				state_d = S_HUNT;
				emit    = 1'b1;
				// end byte is checked ahead of the crc
				if (b != cfg.end_byte) begin
					res.status = ST_BAD_END;
				end else if (!match_q) begin
					res.status = ST_BAD_CRC;
				end else begin
					res.valid_res   = 1'b1;
					res.status      = ST_OK;
					res.cmd         = cmd_q;
					res.table_index = tbl_q;
					res.param       = prm_q;
				end
			end
			default: begin
				// hunting: abort byte wins over a start byte of the same value
				state_d = S_HUNT;
				if (b == ABORT_BYTE) begin
					emit       = 1'b1;
					res.status = ST_HUNT_ABORT;
				end else if (b == cfg.start_byte) begin
					crc_d   = CRC_INIT;
					state_d = S_CMD;
				end
			end
		endcase
	end

	// state registers, advanced once per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_HUNT;
			crc_q   <= CRC_INIT;
			cmd_q   <= '0;
			tbl_q   <= '0;
			prm_q   <= '0;
			match_q <= 1'b0;
		end else if (step) begin
			state_q <= state_d;
			crc_q   <= crc_d;
			cmd_q   <= cmd_d;
			tbl_q   <= tbl_d;
			prm_q   <= prm_d;
			match_q <= match_d;
		end
	end

	// checks
	`CRC8FPR_ASSERT_IMPL(a_emit_from_hunt_or_etx, clk, arst_n, step && emit, state_q == S_ETX || state_q == S_HUNT)
	`CRC8FPR_ASSERT_NEXT(a_crc_then_etx, clk, arst_n, step && state_q == S_CRC, state_q == S_ETX)
	`CRC8FPR_ASSERT_NEXT(a_hold_without_step, clk, arst_n, !step, $stable(state_q) && $stable(crc_q) && $stable(match_q))

endmodule
